// ----- hw/rtl/tarw_pkg.sv -----
// Shared types and constants for the tar header stream walker.
// Holds the phase enum, status and kind codes, header field offsets and the result record.
// No dependencies.
package tarw_pkg;

    // Walker phase
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_HALT   = 2'd2
    } phase_t;

    // Result status codes
    localparam logic [2:0] ST_KEPT    = 3'd0;
    localparam logic [2:0] ST_SKIPPED = 3'd1;
    localparam logic [2:0] ST_EOA     = 3'd2;
    localparam logic [2:0] ST_BAD     = 3'd3;
    localparam logic [2:0] ST_ENDED   = 3'd4;

    // Entry kind codes
    localparam logic [2:0] KIND_REGULAR  = 3'd0;
    localparam logic [2:0] KIND_HARDLINK = 3'd1;
    localparam logic [2:0] KIND_SYMLINK  = 3'd2;
    localparam logic [2:0] KIND_DIR      = 3'd3;
    localparam logic [2:0] KIND_OTHER    = 3'd4;

    // Type flag characters
    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_REG  = 8'h30;
    localparam logic [7:0] CHAR_LINK = 8'h31;
    localparam logic [7:0] CHAR_SYM  = 8'h32;
    localparam logic [7:0] CHAR_DIR  = 8'h35;
    localparam logic [7:0] CHAR_OCT0 = 8'h30;
    localparam logic [7:0] CHAR_OCT7 = 8'h37;

    // Header layout
    localparam int SIZE_AT   = 124;
    localparam int SIZE_LEN  = 12;
    localparam int TYPE_AT   = 156;
    localparam int MAGIC_AT  = 257;
    localparam int MAGIC_LEN = 5;

    // Field widths
    localparam int SIZE_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 3;
    localparam int OFF_W    = 40;
    localparam int IDX_W    = 24;
    localparam int BLK_W    = 24;

    // One result record
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KIND_W-1:0]   entry_kind;
        logic [SIZE_W-1:0]   entry_size;
        logic [OFF_W-1:0]    content_offset;
        logic [IDX_W-1:0]    entry_index;
        logic                halted;
    } result_t;

    // Expected magic character at index 0..4 ("ustar")
    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h75;
            3'd1:    c = 8'h73;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h72;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/tar_header_stream_walker.sv -----
// Top level of the tar header stream walker: stream ports, input and result registers.
// Instantiates tarw_walker; depends on tarw_pkg.
//
//  Channel  | Dir | Signals                        | Carries
//  ---------+-----+--------------------------------+------------------------------------
//  s_       | in  | s_tvalid s_tready s_tdata s_tlast | one archive byte, tlast = last byte
//  m_       | out | m_tvalid m_tready m_tdata m_tuser | one result per header end/halt
//
// One byte per clock unless the output stalls; a byte waits in the input register and
// its result (if any) is captured in the output register when the walker steps on it.
// Header parsing and block skipping are per-byte counter and compare logic in tarw_walker.
// The walker steps only while the output register is free or being taken; an empty
// input register still takes a request while the output stalls.
// rst_n clears all control state and returns the walker to the header phase.
// After halt, further requests are still taken and dropped.
module tar_header_stream_walker #(
    parameter int BLOCK_BYTES = 512,
    parameter int OFFSET_BITS = 40,
    parameter int COUNT_BITS  = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] archive_byte
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // [2:0] entry_kind, [34:3] entry_size,
                                    // [74:35] content_offset, [98:75] entry_index,
                                    // [99] halted, [103:100] zero
    output logic [2:0]   m_tuser    // [2:0] status
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    tarw_pkg::result_t out_reg;
    logic              advance;
    logic              step;
    logic              res_valid;
    tarw_pkg::result_t res;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    tarw_walker #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .OFFSET_BITS (OFFSET_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_walker (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .archive_byte (in_byte_reg),
        .last_byte    (in_last_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {4'b0000, out_reg.halted, out_reg.entry_index,
                       out_reg.content_offset, out_reg.entry_size, out_reg.entry_kind};

endmodule

// ----- hw/rtl/tarw_walker.sv -----
// Walker state for the tar header stream walker: block position, header fields, skip count.
// Takes one byte per step and produces at most one result record in the same cycle.
// Depends on tarw_pkg.
module tarw_walker #(
    parameter int BLOCK_BYTES = 512,
    parameter int OFFSET_BITS = 40,
    parameter int COUNT_BITS  = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        archive_byte,
    input  logic              last_byte,
    output logic              res_valid,
    output tarw_pkg::result_t res
);

    localparam int BIB_W = $clog2(BLOCK_BYTES);
    localparam logic [BIB_W-1:0] BLOCK_END = BIB_W'(BLOCK_BYTES - 1);

    tarw_pkg::phase_t            phase_reg, phase_next;
    logic [BIB_W-1:0]            bib_reg, bib_next;
    logic [tarw_pkg::SIZE_W-1:0] size_reg, size_next;
    logic                        stopped_reg, stopped_next;
    logic                        empty_reg, empty_next;
    logic                        magic_reg, magic_next;
    logic [7:0]                  type_reg, type_next;
    logic [tarw_pkg::BLK_W-1:0]  blocks_reg, blocks_next;
    logic [OFFSET_BITS-1:0]      pos_reg, pos_next;
    logic [COUNT_BITS-1:0]       kept_reg, kept_next;

    logic                        block_end;
    logic                        in_size, in_magic, is_digit;
    logic [tarw_pkg::KIND_W-1:0] kind;
    logic                        kept;
    logic [tarw_pkg::BLK_W-1:0]  blocks_calc;
    logic [tarw_pkg::BLK_W-1:0]  blocks_dec;
    logic [2:0]                  magic_idx;
    logic [tarw_pkg::IDX_W-1:0]  index_out;
    logic [tarw_pkg::OFF_W-1:0]  offset_out;

    assign block_end  = (bib_reg == BLOCK_END);
    assign in_size    = (bib_reg >= BIB_W'(tarw_pkg::SIZE_AT)) &&
                        (bib_reg <  BIB_W'(tarw_pkg::SIZE_AT + tarw_pkg::SIZE_LEN));
    assign in_magic   = (bib_reg >= BIB_W'(tarw_pkg::MAGIC_AT)) &&
                        (bib_reg <  BIB_W'(tarw_pkg::MAGIC_AT + tarw_pkg::MAGIC_LEN));
    assign magic_idx  = 3'(bib_reg - BIB_W'(tarw_pkg::MAGIC_AT));
    assign is_digit   = (archive_byte >= tarw_pkg::CHAR_OCT0) &&
                        (archive_byte <= tarw_pkg::CHAR_OCT7);
    assign index_out  = tarw_pkg::IDX_W'(32'(kept_reg));
    assign offset_out = tarw_pkg::OFF_W'(64'(pos_reg + OFFSET_BITS'(1)));
    assign blocks_dec = blocks_reg - tarw_pkg::BLK_W'(1);

    // Kind decode from the type byte
    always_comb
    begin
        kept = 1'b1;
        unique case (type_reg) inside
            tarw_pkg::CHAR_REG, tarw_pkg::CHAR_NUL: kind = tarw_pkg::KIND_REGULAR;
            tarw_pkg::CHAR_LINK:                    kind = tarw_pkg::KIND_HARDLINK;
            tarw_pkg::CHAR_SYM:                     kind = tarw_pkg::KIND_SYMLINK;
            tarw_pkg::CHAR_DIR:                     kind = tarw_pkg::KIND_DIR;
            default:
            begin
                kind = tarw_pkg::KIND_OTHER;
                kept = 1'b0;
            end
        endcase
    end

    // Data blocks to skip: ceil(size / block)
    assign blocks_calc = tarw_pkg::BLK_W'(size_next >> BIB_W) +
                         tarw_pkg::BLK_W'(|size_next[BIB_W-1:0]);

    // Header field capture and next state
    always_comb
    begin
        phase_next   = phase_reg;
        bib_next     = block_end ? '0 : bib_reg + BIB_W'(1);
        pos_next     = pos_reg + OFFSET_BITS'(1);
        size_next    = size_reg;
        stopped_next = stopped_reg;
        empty_next   = empty_reg;
        magic_next   = magic_reg;
        type_next    = type_reg;
        blocks_next  = blocks_reg;
        kept_next    = kept_reg;
        res_valid    = 1'b0;
        res          = '{status: tarw_pkg::ST_ENDED, entry_kind: tarw_pkg::KIND_REGULAR,
                         entry_size: '0, content_offset: '0, entry_index: index_out,
                         halted: 1'b1};

        if (phase_reg == tarw_pkg::PH_HEADER)
        begin
            // New header: clear the per-header fields
            if (bib_reg == '0)
            begin
                empty_next   = (archive_byte == tarw_pkg::CHAR_NUL);
                size_next    = '0;
                stopped_next = 1'b0;
                magic_next   = 1'b1;
                type_next    = '0;
            end
            // Octal size, stops at first non-digit
            if (in_size && !stopped_next)
            begin
                if (is_digit)
                    size_next = {size_next[tarw_pkg::SIZE_W-4:0], archive_byte[2:0]};
                else
                    stopped_next = 1'b1;
            end
            if (bib_reg == BIB_W'(tarw_pkg::TYPE_AT))
                type_next = archive_byte;
            if (in_magic && archive_byte != tarw_pkg::magic_char(magic_idx))
                magic_next = 1'b0;

            // End of header: report
            if (block_end)
            begin
                res_valid = 1'b1;
                if (empty_next)
                begin
                    res.status = tarw_pkg::ST_EOA;
                    phase_next = tarw_pkg::PH_HALT;
                end
                else if (!magic_next)
                begin
                    res.status = tarw_pkg::ST_BAD;
                    phase_next = tarw_pkg::PH_HALT;
                end
                else
                begin
                    res.status         = kept ? tarw_pkg::ST_KEPT : tarw_pkg::ST_SKIPPED;
                    res.entry_kind     = kind;
                    res.entry_size     = size_next;
                    res.content_offset = offset_out;
                    res.halted         = last_byte;
                    if (kept)
                        kept_next = kept_reg + COUNT_BITS'(1);
                    blocks_next = blocks_calc;
                    if (last_byte)
                        phase_next = tarw_pkg::PH_HALT;
                    else if (blocks_calc != '0)
                        phase_next = tarw_pkg::PH_DATA;
                    else
                        phase_next = tarw_pkg::PH_HEADER;
                end
            end
        end
        else if (phase_reg == tarw_pkg::PH_DATA)
        begin
            // Skip data blocks
            if (block_end)
            begin
                blocks_next = blocks_dec;
                if (blocks_dec == '0)
                    phase_next = tarw_pkg::PH_HEADER;
            end
        end

        // Buffer ended away from a header end
        if (phase_reg != tarw_pkg::PH_HALT && last_byte && !res_valid)
        begin
            res_valid  = 1'b1;
            phase_next = tarw_pkg::PH_HALT;
        end

        // Halted: bytes are dropped without any change
        if (phase_reg == tarw_pkg::PH_HALT)
        begin
            bib_next = bib_reg;
            pos_next = pos_reg;
        end

        if (!step)
            res_valid = 1'b0;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= tarw_pkg::PH_HEADER;
            bib_reg     <= '0;
            size_reg    <= '0;
            stopped_reg <= 1'b0;
            empty_reg   <= 1'b0;
            magic_reg   <= 1'b1;
            type_reg    <= '0;
            blocks_reg  <= '0;
            pos_reg     <= '0;
            kept_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            bib_reg     <= bib_next;
            size_reg    <= size_next;
            stopped_reg <= stopped_next;
            empty_reg   <= empty_next;
            magic_reg   <= magic_next;
            type_reg    <= type_next;
            blocks_reg  <= blocks_next;
            pos_reg     <= pos_next;
            kept_reg    <= kept_next;
        end
    end

    // Halt is sticky until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == tarw_pkg::PH_HALT |=> phase_reg == tarw_pkg::PH_HALT)
        else $error("walker left halt without reset");

    // Phase changes into header or data only at a block boundary
    a_phase_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != $past(phase_reg) && phase_reg != tarw_pkg::PH_HALT) |-> bib_reg == '0)
        else $error("phase changed inside a block");

    // A result that does not halt is always an entry report
    a_entry_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.halted) |->
        (res.status == tarw_pkg::ST_KEPT || res.status == tarw_pkg::ST_SKIPPED))
        else $error("non-entry result without halt");

    // Results come only from an accepted byte outside halt
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (step && phase_reg != tarw_pkg::PH_HALT))
        else $error("result without a live byte");

endmodule

// ----- tb/sv/tar_header_stream_walker_tb.sv -----
// Testbench for tar_header_stream_walker: feeds byte streams of ustar archives and checks
// every report against an in-bench walker that follows the same rules.
// Depends on tarw_pkg and the tar_header_stream_walker RTL; reads no files.
module tar_header_stream_walker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLOCK_LEN = 512;
    // Longest run with no request taken: geometric stalls at 17 percent plus a drain
    // pause; this is far above any correct run.
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [39:0] USTAR_TEXT = "ustar";

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;       // [7:0] archive_byte
    logic         s_tlast = 1'b0;        // last_byte
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;               // [2:0] kind, [34:3] size, [74:35] offset,
                                         // [98:75] index, [99] halted, [103:100] zero
    logic [2:0]   m_tuser;               // [2:0] status

    tar_header_stream_walker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    // Walker state as the bench tracks it
    tarw_pkg::phase_t wk_phase;
    logic [8:0]  wk_pos;
    logic [31:0] wk_size;
    logic        wk_size_done;
    logic        wk_name_empty;
    logic        wk_magic_ok;
    logic [7:0]  wk_type;
    logic [23:0] wk_blocks;
    logic [39:0] wk_bytes;
    logic [23:0] wk_kept;

    tarw_pkg::result_t pending_reports[$];
    logic [7:0]  hdr [BLOCK_LEN];

    int unsigned src_idle_pct = 17;
    int unsigned sink_idle_pct = 17;
    int          mismatch_count = 0;
    int          reports_checked = 0;
    int          entries_walked = 0;
    int          bytes_sent = 0;
    int          stall_cycles = 0;
    string       ending_name = "none";

    // Advance the walker by one archive byte and queue the report it causes
    task automatic walk_archive_byte(input logic [7:0] b, input logic lst);
        logic       block_end;
        logic       reported;
        logic [2:0] kind;
        int         mi;
        tarw_pkg::result_t r;
        block_end = (wk_pos == 9'(BLOCK_LEN - 1));
        reported = 1'b0;
        r = '0;
        if (wk_phase == tarw_pkg::PH_HALT)
            return;
        if (wk_phase == tarw_pkg::PH_HEADER)
        begin
            if (wk_pos == 9'd0)
            begin
                wk_name_empty = (b == tarw_pkg::CHAR_NUL);
                wk_size = '0;
                wk_size_done = 1'b0;
                wk_magic_ok = 1'b1;
                wk_type = '0;
            end
            // octal size field, stops for good at the first non-digit
            if (wk_pos >= tarw_pkg::SIZE_AT && wk_pos < tarw_pkg::SIZE_AT + tarw_pkg::SIZE_LEN
                && !wk_size_done)
            begin
                if (b >= tarw_pkg::CHAR_OCT0 && b <= tarw_pkg::CHAR_OCT7)
                    wk_size = (wk_size << 3) + 32'(b - tarw_pkg::CHAR_OCT0);
                else
                    wk_size_done = 1'b1;
            end
            if (wk_pos == tarw_pkg::TYPE_AT)
                wk_type = b;
            mi = int'(wk_pos) - tarw_pkg::MAGIC_AT;
            if (mi >= 0 && mi < tarw_pkg::MAGIC_LEN &&
                b != USTAR_TEXT[8*(tarw_pkg::MAGIC_LEN-1-mi) +: 8])
                wk_magic_ok = 1'b0;
            if (block_end)
            begin
                r.entry_index = wk_kept;
                r.halted = 1'b1;
                if (wk_name_empty)
                begin
                    r.status = tarw_pkg::ST_EOA;
                    wk_phase = tarw_pkg::PH_HALT;
                end
                else if (!wk_magic_ok)
                begin
                    r.status = tarw_pkg::ST_BAD;
                    wk_phase = tarw_pkg::PH_HALT;
                end
                else
                begin
                    case (wk_type)
                        tarw_pkg::CHAR_NUL, tarw_pkg::CHAR_REG: kind = tarw_pkg::KIND_REGULAR;
                        tarw_pkg::CHAR_LINK:                    kind = tarw_pkg::KIND_HARDLINK;
                        tarw_pkg::CHAR_SYM:                     kind = tarw_pkg::KIND_SYMLINK;
                        tarw_pkg::CHAR_DIR:                     kind = tarw_pkg::KIND_DIR;
                        default:                                kind = tarw_pkg::KIND_OTHER;
                    endcase
                    r.status = (kind == tarw_pkg::KIND_OTHER) ? tarw_pkg::ST_SKIPPED
                                                              : tarw_pkg::ST_KEPT;
                    r.entry_kind = kind;
                    r.entry_size = wk_size;
                    r.content_offset = wk_bytes + 40'd1;
                    r.halted = lst;
                    if (kind != tarw_pkg::KIND_OTHER)
                        wk_kept = wk_kept + 24'd1;
                    wk_blocks = 24'((wk_size >> 9) + 32'(wk_size[8:0] != 9'd0));
                    if (lst)
                        wk_phase = tarw_pkg::PH_HALT;
                    else if (wk_blocks != 24'd0)
                        wk_phase = tarw_pkg::PH_DATA;
                    else
                        wk_phase = tarw_pkg::PH_HEADER;
                end
                pending_reports.push_back(r);
                reported = 1'b1;
            end
        end
        else if (block_end)
        begin
            // data skip: one block done
            wk_blocks = wk_blocks - 24'd1;
            if (wk_blocks == 24'd0)
                wk_phase = tarw_pkg::PH_HEADER;
        end
        // buffer ran out somewhere other than a header end
        if (lst && !reported)
        begin
            r = '0;
            r.status = tarw_pkg::ST_ENDED;
            r.entry_index = wk_kept;
            r.halted = 1'b1;
            pending_reports.push_back(r);
            wk_phase = tarw_pkg::PH_HALT;
        end
        wk_pos = block_end ? 9'd0 : wk_pos + 9'd1;
        wk_bytes = wk_bytes + 40'd1;
    endtask

    // Send one byte request, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        walk_archive_byte(b, lst);
        bytes_sent++;
    endtask

    // Random header around the given name byte and type flag, with good magic
    task automatic fill_header(input logic [7:0] name0, input logic [7:0] type_char);
        for (int i = 0; i < BLOCK_LEN; i++)
            hdr[i] = 8'($urandom);
        hdr[0] = name0;
        hdr[tarw_pkg::TYPE_AT] = type_char;
        for (int i = 0; i < tarw_pkg::MAGIC_LEN; i++)
            hdr[tarw_pkg::MAGIC_AT + i] = USTAR_TEXT[8*(tarw_pkg::MAGIC_LEN-1-i) +: 8];
    endtask

    // Size field text; a shorter text is closed by stop_char
    task automatic put_size(input string txt, input logic [7:0] stop_char);
        for (int i = 0; i < txt.len() && i < tarw_pkg::SIZE_LEN; i++)
            hdr[tarw_pkg::SIZE_AT + i] = txt[i];
        if (txt.len() < tarw_pkg::SIZE_LEN)
            hdr[tarw_pkg::SIZE_AT + txt.len()] = stop_char;
    endtask

    function automatic logic [7:0] non_octal_char();
        logic [7:0] c;
        do
            c = 8'($urandom);
        while (c >= tarw_pkg::CHAR_OCT0 && c <= tarw_pkg::CHAR_OCT7);
        return c;
    endfunction

    function automatic logic [7:0] random_type_char();
        logic [7:0] c;
        case ($urandom_range(6))
            0:       c = tarw_pkg::CHAR_REG;
            1:       c = tarw_pkg::CHAR_NUL;
            2:       c = tarw_pkg::CHAR_LINK;
            3:       c = tarw_pkg::CHAR_SYM;
            4:       c = tarw_pkg::CHAR_DIR;
            default: c = 8'($urandom);
        endcase
        return c;
    endfunction

    task automatic send_header(input int last_at);
        for (int i = 0; i < BLOCK_LEN; i++)
            send_byte(hdr[i], i == last_at);
    endtask

    // Header in hdr, then whatever data blocks its size calls for
    task automatic send_entry();
        send_header(-1);
        entries_walked++;
        while (wk_phase == tarw_pkg::PH_DATA)
            send_byte(8'($urandom), 1'b0);
    endtask

    task automatic send_sized_entry(input string txt, input logic [7:0] stop_char);
        fill_header(8'($urandom_range(1, 255)), tarw_pkg::CHAR_REG);
        put_size(txt, stop_char);
        send_entry();
    endtask

    // Every type flag, including unknown ones that are skipped
    task automatic test_entry_kinds();
        logic [7:0] flags [7];
        flags = '{tarw_pkg::CHAR_REG, tarw_pkg::CHAR_NUL, tarw_pkg::CHAR_LINK,
                  tarw_pkg::CHAR_SYM, tarw_pkg::CHAR_DIR, 8'h78, 8'hFF};
        for (int i = 0; i < 7; i++)
        begin
            fill_header(i == 0 ? 8'h01 : (i == 1 ? 8'hFF : 8'($urandom_range(1, 255))),
                        flags[i]);
            put_size("00000000000", tarw_pkg::CHAR_NUL);
            send_entry();
        end
    endtask

    // Size field parsing: block rounding, stop characters, full width, 32-bit wrap
    task automatic test_size_field();
        send_sized_entry("00000001000", tarw_pkg::CHAR_NUL);   // exactly one block
        send_sized_entry("1001", 8'h20);                       // one byte into a second block
        send_sized_entry("777", tarw_pkg::CHAR_NUL);
        send_sized_entry("12", 8'h38);                         // '8' is not octal
        send_sized_entry("", 8'h20);                           // leading space gives zero
        send_sized_entry("", 8'hFF);
        send_sized_entry("40000000001", tarw_pkg::CHAR_NUL);   // 2^32 + 1 keeps the low word
        // all twelve digits used; the digit after the field must not be read
        fill_header(8'($urandom_range(1, 255)), tarw_pkg::CHAR_DIR);
        put_size("000000000017", tarw_pkg::CHAR_NUL);
        hdr[tarw_pkg::SIZE_AT + tarw_pkg::SIZE_LEN] = tarw_pkg::CHAR_OCT7;
        send_entry();
    endtask

    // Hold back requests until every pending report has come out
    task automatic test_drain_pause();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports.size() != 0);
    endtask

    // Well-formed archive with random sizes, flags and content
    task automatic test_random_archive(input int entries);
        string      txt;
        logic [7:0] stop_char;
        int unsigned v;
        for (int n = 0; n < entries; n++)
        begin
            // a stretch with no idling on either side
            src_idle_pct = (n >= 15 && n < 25) ? 0 : 17;
            sink_idle_pct = src_idle_pct;
            v = ($urandom_range(9) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, 1600);
            stop_char = tarw_pkg::CHAR_NUL;
            case ($urandom_range(9))
                0, 1, 2, 3: txt = $sformatf("%011o", v);
                4:
                begin
                    txt = $sformatf("%0o", v);
                    stop_char = 8'h20;
                end
                5:       txt = $sformatf("%012o", v);
                6:       txt = $sformatf("%0o%011o", $urandom_range(1, 7), v);
                7:
                begin
                    txt = $sformatf("%0o", v);
                    stop_char = non_octal_char();
                end
                default:
                begin
                    txt = "";
                    stop_char = non_octal_char();
                end
            endcase
            fill_header(8'($urandom_range(1, 255)), random_type_char());
            put_size(txt, stop_char);
            send_entry();
        end
        src_idle_pct = 17;
        sink_idle_pct = 17;
    endtask

    // One of the ways an archive stops, then requests that must be dropped
    task automatic test_archive_end();
        int total;
        int at;
        case ($urandom_range(4))
            0:
            begin
                ending_name = "end-of-archive header";
                fill_header(tarw_pkg::CHAR_NUL, random_type_char());
                put_size($sformatf("%011o", $urandom_range(0, 4096)), tarw_pkg::CHAR_NUL);
                // empty name wins over a broken magic
                if ($urandom_range(1))
                    hdr[tarw_pkg::MAGIC_AT + $urandom_range(tarw_pkg::MAGIC_LEN - 1)] ^=
                        8'($urandom_range(1, 255));
                send_header(-1);
            end
            1:
            begin
                ending_name = "bad magic";
                fill_header(8'($urandom_range(1, 255)), random_type_char());
                put_size("0", tarw_pkg::CHAR_NUL);
                hdr[tarw_pkg::MAGIC_AT + $urandom_range(tarw_pkg::MAGIC_LEN - 1)] ^=
                    8'($urandom_range(1, 255));
                send_header(-1);
            end
            2:
            begin
                ending_name = "last byte on a header end";
                fill_header(8'($urandom_range(1, 255)), random_type_char());
                put_size($sformatf("%011o", $urandom), tarw_pkg::CHAR_NUL);
                send_header(BLOCK_LEN - 1);
            end
            3:
            begin
                ending_name = "last byte inside a header";
                fill_header(8'($urandom_range(1, 255)), random_type_char());
                send_header($urandom_range(0, BLOCK_LEN - 2));
            end
            default:
            begin
                ending_name = "last byte inside file data";
                fill_header(8'($urandom_range(1, 255)), tarw_pkg::CHAR_REG);
                put_size($sformatf("%011o", $urandom_range(1, 3 * BLOCK_LEN)),
                         tarw_pkg::CHAR_NUL);
                send_header(-1);
                total = int'(wk_blocks) * BLOCK_LEN;
                at = $urandom_range(0, total - 1);
                for (int i = 0; i <= at; i++)
                    send_byte(8'($urandom), i == at);
            end
        endcase
        repeat (20)
            send_byte(8'($urandom), 1'($urandom));
    endtask

    function automatic void check_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endfunction

    // Receiver back-pressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_idle_pct);

    // Compare each report taken against the oldest one pending
    always @(posedge clk)
    begin : report_check
        tarw_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_reports.size() == 0)
            begin
                mismatch_count++;
                $display("%0t ns: unexpected report, expected none, actual status %0d data %h",
                         $time, m_tuser, m_tdata);
            end
            else
            begin
                want = pending_reports.pop_front();
                reports_checked++;
                check_field("status", 64'(want.status), 64'(m_tuser));
                check_field("entry_kind", 64'(want.entry_kind), 64'(m_tdata[2:0]));
                check_field("entry_size", 64'(want.entry_size), 64'(m_tdata[34:3]));
                check_field("content_offset", 64'(want.content_offset), 64'(m_tdata[74:35]));
                check_field("entry_index", 64'(want.entry_index), 64'(m_tdata[98:75]));
                check_field("halted", 64'(want.halted), 64'(m_tdata[99]));
                check_field("pad bits", 64'd0, 64'(m_tdata[103:100]));
            end
        end
    end

    // Watchdog on cycles with no request taken on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: watchdog, no request taken for %0d cycles", $time, STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        wk_phase = tarw_pkg::PH_HEADER;
        wk_pos = '0;
        wk_size = '0;
        wk_size_done = 1'b0;
        wk_name_empty = 1'b0;
        wk_magic_ok = 1'b1;
        wk_type = '0;
        wk_blocks = '0;
        wk_bytes = '0;
        wk_kept = '0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        test_entry_kinds();
        test_size_field();
        test_drain_pause();
        test_random_archive(40);
        test_archive_end();

        // let the last reports out, then watch for strays
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports.size() != 0);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("Walked %0d archive entries over %0d bytes, %0d reports checked",
                 entries_walked, bytes_sent, reports_checked);
        $display("Archive ended by %s", ending_name);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/tarw_pkg.sv
hw/rtl/tarw_walker.sv
hw/rtl/tar_header_stream_walker.sv
tb/sv/tar_header_stream_walker_tb.sv
